[hw/rtl/ffba_pkg.sv]
// Shared constants and types for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned MaxBlocks   = 256;
  localparam int unsigned IdxW        = $clog2(MaxBlocks);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned SizeW       = 17;
  localparam logic [SizeW-1:0] ArenaLimit = SizeW'(65536);
  localparam logic [SizeW-1:0] ArenaReset = SizeW'(4096);

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StNoFit    = 2'd1,
    StNotFound = 2'd2
  } status_e;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // One table entry: payload size and used flag.
  typedef struct packed {
    logic             used;
    logic [SizeW-1:0] size;
  } entry_t;
endpackage
`default_nettype wire

[hw/rtl/first_fit_block_allocator_core.sv]
// Top level of the first-fit block allocator with coalescing.
// Use: send one command word on s_axis (allocate or free), take one result
// word on m_axis. Write the arena size on the cfg channel while idle; this
// re-initializes the arena as one free block and frees everything.
// Each command walks the block table, one entry at a time through the
// table memory's single read port, and shifts entries one at a time
// when a split inserts or a merge removes one; one command is in flight
// at a time and s_axis_tready is low from acceptance until the result
// word is taken.
// Entries at or beyond the block count are never read, so reset needs no
// clearing pass: reset sets one free block spanning 4096 bytes minus one
// header and zero blocks in use. The first entry is written in the SInit
// state, entered on reset or a cfg write, during which s_axis is held.
// When m_axis stalls the result word holds in its register and the block
// waits; the next command is accepted once the word is taken.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [0] command, [16:1] request_bytes, [32:17] free_offset, [39:33] zero
  input  wire logic [39:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [17:2] payload_offset, [26:18] blocks_in_use, [31:27] zero
  output      logic [31:0] m_axis_tdata
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    SInit, SIdle, SRead, SScan, SShUpRd, SShUpWr, SAllocWr,
    SFreeNx, SFreeNxChk, SRemRd, SRemWr, SFreePv, SFreePvChk, SOut
  } state_e;

  state_e           state_q;
  logic [SizeW-1:0] arena_q;
  logic [CntW-1:0]  total_q, used_q;
  logic [IdxW-1:0]  idx_q, k_q;
  logic [SizeW-1:0] pos_q;
  logic             cmd_q;
  logic [15:0]      req_q, off_q;
  entry_t           cur_q;       // entry at idx_q being worked on
  logic [CntW-1:0]  rem_q;       // index being removed
  logic             pv_q;        // previous-merge still pending
  logic [1:0]       st_q;
  logic [15:0]      gr_q;
  logic             ovalid_q;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  entry_t           wdata, rdata;

  ffba_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [SizeW-1:0] a_cl, init_size, payload, left;
  assign a_cl      = (arena_q > ArenaLimit) ? ArenaLimit : arena_q;
  assign init_size = (a_cl > SizeW'(HeaderBytes)) ? a_cl - SizeW'(HeaderBytes) : '0;
  assign payload   = pos_q + SizeW'(HeaderBytes);
  assign left      = cur_q.size - {1'b0, req_q};

  assign cfg_ready_o   = (state_q == SIdle);
  assign s_axis_tready = (state_q == SIdle) && !cfg_valid_i;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, used_q, gr_q, st_q};

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = cur_q;
    raddr = idx_q;
    case (state_q)
      SInit: begin
        we = 1'b1; waddr = '0; wdata = '{used: 1'b0, size: init_size};
      end
      SShUpRd:  raddr = k_q - IdxW'(1);
      SShUpWr: begin
        we = 1'b1; waddr = k_q;
        wdata = (k_q == idx_q + IdxW'(1)) ?
                '{used: 1'b0, size: left - SizeW'(HeaderBytes)} : rdata;
      end
      SAllocWr: begin
        we = 1'b1; waddr = idx_q; wdata = cur_q;
      end
      SFreeNx:  raddr = idx_q + IdxW'(1);
      SFreePv:  raddr = idx_q - IdxW'(1);
      SRemRd:   raddr = k_q + IdxW'(1);
      SRemWr: begin
        we = 1'b1; waddr = k_q; wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SInit;
      arena_q  <= ArenaReset;
      total_q  <= CntW'(1);
      used_q   <= '0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      k_q      <= '0;
      pv_q     <= 1'b0;
      pos_q    <= '0;
      cmd_q    <= CmdAlloc;
      req_q    <= '0;
      off_q    <= '0;
      cur_q    <= '0;
      rem_q    <= '0;
      st_q     <= StDone;
      gr_q     <= '0;
    end else begin
      case (state_q)
        SInit: begin
          total_q <= CntW'(1);
          used_q  <= '0;
          state_q <= SIdle;
        end
        SIdle: begin
          if (cfg_valid_i) begin
            arena_q <= cfg_data_i;
            state_q <= SInit;
          end else if (s_axis_tvalid) begin
            cmd_q   <= s_axis_tdata[0];
            req_q   <= s_axis_tdata[16:1];
            off_q   <= s_axis_tdata[32:17];
            idx_q   <= '0;
            pos_q   <= '0;
            st_q    <= StDone;
            gr_q    <= '0;
            state_q <= SRead;
          end
        end
        SRead: state_q <= SScan;  // read data lands next cycle
        SScan: begin
          if (cmd_q == CmdAlloc && !rdata.used && rdata.size >= {1'b0, req_q}) begin
            // Mark the granted entry used; it is written back in SAllocWr.
            cur_q <= '{used: 1'b1, size: rdata.size};
            gr_q  <= payload[15:0];
            k_q   <= total_q[IdxW-1:0];
            if ((rdata.size - {1'b0, req_q}) > SizeW'(HeaderBytes) &&
                total_q < CntW'(MaxBlocks)) begin
              state_q <= SShUpRd;
            end else begin
              state_q <= SAllocWr;
            end
          end else if (cmd_q == CmdFree && payload == {1'b0, off_q}) begin
            if (!rdata.used) begin
              cur_q <= rdata;
              st_q <= StNotFound; state_q <= SOut;
            end else begin
              cur_q   <= '{used: 1'b0, size: rdata.size};
              used_q  <= used_q - CntW'(1);
              pv_q    <= (idx_q != '0);
              state_q <= (CntW'(idx_q) + CntW'(1) < total_q) ? SFreeNx : SAllocWr;
            end
          end else if (CntW'(idx_q) + CntW'(1) >= total_q) begin
            cur_q   <= rdata;
            st_q    <= (cmd_q == CmdAlloc) ? StNoFit : StNotFound;
            state_q <= SOut;
          end else begin
            cur_q   <= rdata;
            pos_q   <= payload + rdata.size;
            idx_q   <= idx_q + IdxW'(1);
            state_q <= SRead;
          end
        end
        SShUpRd: state_q <= SShUpWr;
        SShUpWr: begin
          if (k_q == idx_q + IdxW'(1)) begin
            total_q    <= total_q + CntW'(1);
            cur_q.size <= {1'b0, req_q};
            state_q    <= SAllocWr;
          end else begin
            k_q     <= k_q - IdxW'(1);
            state_q <= SShUpRd;
          end
        end
        SAllocWr: begin
          // Write back cur; for alloc count the new block.
          if (cmd_q == CmdAlloc) begin
            used_q  <= used_q + CntW'(1);
            state_q <= SOut;
          end else if (pv_q) begin
            state_q <= SFreePv;
          end else begin
            state_q <= SOut;
          end
        end
        SFreeNx: state_q <= SFreeNxChk;
        SFreeNxChk: begin
          if (!rdata.used) begin
            cur_q.size <= cur_q.size + SizeW'(HeaderBytes) + rdata.size;
            rem_q   <= CntW'(idx_q) + CntW'(1);
            k_q     <= idx_q + IdxW'(1);
            state_q <= (CntW'(idx_q) + CntW'(2) < total_q) ? SRemRd : SRemWr;
          end else begin
            state_q <= SAllocWr;
          end
        end
        SRemRd: state_q <= SRemWr;
        SRemWr: begin
          if (CntW'(k_q) + CntW'(2) < total_q) begin
            k_q <= k_q + IdxW'(1); state_q <= SRemRd;
          end else begin
            total_q <= total_q - CntW'(1);
            if (rem_q == CntW'(idx_q)) begin
              idx_q   <= idx_q - IdxW'(1);
              state_q <= SAllocWr;
              pv_q    <= 1'b0;
            end else begin
              state_q <= SAllocWr;
            end
          end
        end
        SFreePv: state_q <= SFreePvChk;
        SFreePvChk: begin
          pv_q <= 1'b0;
          if (!rdata.used) begin
            // Merge into previous: remove entry idx, then write prev.
            rem_q   <= CntW'(idx_q);
            k_q     <= idx_q;
            cur_q   <= '{used: 1'b0,
                         size: rdata.size + SizeW'(HeaderBytes) + cur_q.size};
            state_q <= (CntW'(idx_q) + CntW'(1) < total_q) ? SRemRd : SRemWr;
          end else begin
            state_q <= SOut;
          end
        end
        SOut: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
          end else if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/ffba_ram.sv]
// Block table storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ffba_pkg::IdxW-1:0] waddr_i,
  input  wire ffba_pkg::entry_t      wdata_i,
  input  wire logic [ffba_pkg::IdxW-1:0] raddr_i,
  output      ffba_pkg::entry_t      rdata_o
);
  import ffba_pkg::*;
  entry_t mem [MaxBlocks];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
